>>> hdl/assert_macros.svh
// assert_macros.svh: concurrent assertion helpers for the ray/box core.
// No dependencies; compiled away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RBI_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RBI_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define RBI_ASSERT(lbl, clk, rst, prop, msg)
`define RBI_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

>>> hdl/rbi_pkg.sv
// rbi_pkg: word types, register indexes and constants of the ray/box core.
// No dependencies.
`default_nettype none

package rbi_pkg;

  localparam int FIELD_W         = 32;
  localparam int T_W             = 32;
  localparam int CFG_IDX_W       = 3;
  localparam int AXES            = 3;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // clamp limits of t
  localparam logic [T_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [T_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic signed [FIELD_W-1:0] start_x;
    logic signed [FIELD_W-1:0] start_y;
    logic signed [FIELD_W-1:0] start_z;
    logic signed [FIELD_W-1:0] dir_x;
    logic signed [FIELD_W-1:0] dir_y;
    logic signed [FIELD_W-1:0] dir_z;
  } ray_t;

  typedef struct packed {
    logic                    hit;
    logic signed [T_W-1:0]   ray_param;
    logic                    param_saturated;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/ray_box_intersection_core.sv
// ray_box_intersection_core: pipelined ray versus axis-aligned box test.
// Depends on rbi_pkg and assert_macros.svh.
`default_nettype none

// A ray word (start point and direction) is taken on any cycle where start
// is high and busy is low; busy is only high during reset and in the cycle
// after it. One ray per cycle is sustained, and every ray gives exactly one
// result word, through four front stages, one restoring-divider stage per
// quotient bit and four back stages, shown on result for one cycle with
// result_valid high. The receiver cannot stall, and nothing here ever
// needs it to. The box corners are written through the cfg channel, which
// is always ready; write it only while no ray is in flight. Coordinates are
// signed fixed point with FRAC_BITS fraction bits; t is clamped to 32 bits
// and param_saturated flags the clamp.

`include "assert_macros.svh"

module ray_box_intersection_core #(
  parameter int COORD_WIDTH = rbi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rbi_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire rbi_pkg::ray_t                   ray,
  output logic                                 result_valid,
  output rbi_pkg::result_t                     result,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [rbi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rbi_pkg::FIELD_W-1:0]     cfg_data
);

  localparam int CW  = COORD_WIDTH;
  localparam int QW  = rbi_pkg::T_W;
  localparam int PW  = 2 * CW + 1;           // n * d cross products
  localparam int XW  = CW + FRAC_BITS + QW + 2; // divider remainder
  localparam int MW  = QW + CW;              // |t| * |dir|
  localparam int LW  = (MW > 52) ? MW : 52;
  localparam int HW  = 53;                   // hit point
  localparam int LAT = QW + 8;

  typedef struct packed {
    logic                 neg;
    logic                 sat;
    logic                 has;
    logic                 inside_all;
    logic [1:0]           a1;
    logic [1:0]           a2;
    logic signed [CW-1:0] sa1;
    logic signed [CW-1:0] da1;
    logic signed [CW-1:0] sa2;
    logic signed [CW-1:0] da2;
  } carry_t;

  function automatic logic signed [CW-1:0] to_cw(input logic signed [31:0] v);
    logic signed [63:0] e;
    e = 64'(v);
    return e[CW-1:0];
  endfunction

  // ---------------------------------------------------------------- config
  logic signed [CW-1:0] box_min_x, box_min_y, box_min_z;
  logic signed [CW-1:0] box_max_x, box_max_y, box_max_z;
  logic signed [CW-1:0] lo_w [3];
  logic signed [CW-1:0] hi_w [3];

  assign cfg_ready = 1'b1;
  assign lo_w[0] = box_min_x;
  assign lo_w[1] = box_min_y;
  assign lo_w[2] = box_min_z;
  assign hi_w[0] = box_max_x;
  assign hi_w[1] = box_max_y;
  assign hi_w[2] = box_max_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_min_x <= '0;
      box_min_y <= '0;
      box_min_z <= '0;
      box_max_x <= '0;
      box_max_y <= '0;
      box_max_z <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rbi_pkg::REG_BOX_MIN_X: box_min_x <= to_cw(cfg_data);
        rbi_pkg::REG_BOX_MIN_Y: box_min_y <= to_cw(cfg_data);
        rbi_pkg::REG_BOX_MIN_Z: box_min_z <= to_cw(cfg_data);
        rbi_pkg::REG_BOX_MAX_X: box_max_x <= to_cw(cfg_data);
        rbi_pkg::REG_BOX_MAX_Y: box_max_y <= to_cw(cfg_data);
        rbi_pkg::REG_BOX_MAX_Z: box_max_z <= to_cw(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) busy <= 1'b1;
    else     busy <= 1'b0;
  end

  wire accept = start && !busy;

  // ---------------------------------------------------- stage 1: classify
  logic signed [CW-1:0] in_st [3];
  logic signed [CW-1:0] in_dr [3];
  logic signed [CW-1:0] c_face [3];
  logic signed [CW:0]   c_f [3];
  logic                 c_below [3];
  logic                 c_above [3];

  assign in_st[0] = to_cw(ray.start_x);
  assign in_st[1] = to_cw(ray.start_y);
  assign in_st[2] = to_cw(ray.start_z);
  assign in_dr[0] = to_cw(ray.dir_x);
  assign in_dr[1] = to_cw(ray.dir_y);
  assign in_dr[2] = to_cw(ray.dir_z);

  logic                 s1_v;
  logic signed [CW-1:0] s1_st [3];
  logic signed [CW-1:0] s1_dr [3];
  logic [CW:0]          s1_n [3];
  logic [CW-1:0]        s1_d [3];
  logic                 s1_cand [3];
  logic                 s1_in [3];
  logic                 s1_neg [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_below[i] = in_st[i] < lo_w[i];
      c_above[i] = !c_below[i] && (in_st[i] > hi_w[i]);
      c_face[i]  = c_below[i] ? lo_w[i] : hi_w[i];
      c_f[i]     = (CW+1)'(in_st[i]) - (CW+1)'(c_face[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else     s1_v <= accept;
    for (int i = 0; i < 3; i++) begin
      s1_st[i]   <= in_st[i];
      s1_dr[i]   <= in_dr[i];
      s1_n[i]    <= c_f[i][CW] ? (CW+1)'(-c_f[i]) : (CW+1)'(c_f[i]);
      s1_d[i]    <= in_dr[i][CW-1] ? CW'(-in_dr[i]) : CW'(in_dr[i]);
      s1_cand[i] <= (c_below[i] || c_above[i]) && (in_dr[i] != '0);
      s1_in[i]   <= !c_below[i] && !c_above[i];
      s1_neg[i]  <= c_f[i][CW] == in_dr[i][CW-1];
    end
  end

  // ------------------------------------------- stage 2: cross products
  logic                 s2_v;
  logic signed [CW-1:0] s2_st [3];
  logic signed [CW-1:0] s2_dr [3];
  logic [CW:0]          s2_n [3];
  logic [CW-1:0]        s2_d [3];
  logic                 s2_cand [3];
  logic                 s2_in [3];
  logic                 s2_neg [3];
  logic [PW-1:0]        s2_p [3][3];   // n_i * d_j

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else     s2_v <= s1_v;
    for (int i = 0; i < 3; i++) begin
      s2_st[i]   <= s1_st[i];
      s2_dr[i]   <= s1_dr[i];
      s2_n[i]    <= s1_n[i];
      s2_d[i]    <= s1_d[i];
      s2_cand[i] <= s1_cand[i];
      s2_in[i]   <= s1_in[i];
      s2_neg[i]  <= s1_neg[i];
      for (int j = 0; j < 3; j++) begin
        s2_p[i][j] <= PW'(s1_n[i]) * PW'(s1_d[j]);
      end
    end
  end

  // ------------------------------------------- stage 3: pick entry axis
  logic       sel_has;
  logic [1:0] sel_best;
  logic [CW:0]   sel_n;
  logic [CW-1:0] sel_d;
  carry_t        sel_c;

  always_comb begin
    sel_has  = 1'b0;
    sel_best = rbi_pkg::AXIS_X;
    if (s2_cand[0]) begin
      sel_has  = 1'b1;
      sel_best = rbi_pkg::AXIS_X;
    end
    if (s2_cand[1] && (!sel_has || (s2_p[1][0] > s2_p[0][1]))) begin
      sel_has  = 1'b1;
      sel_best = rbi_pkg::AXIS_Y;
    end
    // strict compare: the earlier axis keeps ties
    if (s2_cand[2] && (!sel_has ||
        ((sel_best == rbi_pkg::AXIS_Y) ? (s2_p[2][1] > s2_p[1][2])
                                       : (s2_p[2][0] > s2_p[0][2])))) begin
      sel_has  = 1'b1;
      sel_best = rbi_pkg::AXIS_Z;
    end

    sel_c            = '0;
    sel_c.has        = sel_has;
    sel_c.inside_all = s2_in[0] && s2_in[1] && s2_in[2];
    unique case (sel_best)
      rbi_pkg::AXIS_X: begin
        sel_n = s2_n[0]; sel_d = s2_d[0]; sel_c.neg = s2_neg[0];
        sel_c.a1 = rbi_pkg::AXIS_Y; sel_c.a2 = rbi_pkg::AXIS_Z;
        sel_c.sa1 = s2_st[1]; sel_c.da1 = s2_dr[1];
        sel_c.sa2 = s2_st[2]; sel_c.da2 = s2_dr[2];
      end
      rbi_pkg::AXIS_Y: begin
        sel_n = s2_n[1]; sel_d = s2_d[1]; sel_c.neg = s2_neg[1];
        sel_c.a1 = rbi_pkg::AXIS_Z; sel_c.a2 = rbi_pkg::AXIS_X;
        sel_c.sa1 = s2_st[2]; sel_c.da1 = s2_dr[2];
        sel_c.sa2 = s2_st[0]; sel_c.da2 = s2_dr[0];
      end
      default: begin
        sel_n = s2_n[2]; sel_d = s2_d[2]; sel_c.neg = s2_neg[2];
        sel_c.a1 = rbi_pkg::AXIS_X; sel_c.a2 = rbi_pkg::AXIS_Y;
        sel_c.sa1 = s2_st[0]; sel_c.da1 = s2_dr[0];
        sel_c.sa2 = s2_st[1]; sel_c.da2 = s2_dr[1];
      end
    endcase
  end

  logic          s3_v;
  logic [CW:0]   s3_n;
  logic [CW-1:0] s3_d;
  carry_t        s3_c;

  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else     s3_v <= s2_v;
    s3_n <= sel_n;
    s3_d <= sel_d;
    s3_c <= sel_c;
  end

  // --------------------------- stage 4: saturation test, divider load
  // q = floor(n * 2^F / d) overflows the limit exactly when
  // n * 2^F >= (limit + 1) * d; limit + 1 is 2^31, or 2^31 + 1 when negative.
  logic [XW-1:0] sat_num, sat_bound;
  carry_t        ld_c;

  assign sat_num   = XW'(s3_n) << FRAC_BITS;
  assign sat_bound = (XW'(s3_d) << (QW - 1)) + (s3_c.neg ? XW'(s3_d) : '0);

  always_comb begin
    ld_c     = s3_c;
    ld_c.sat = sat_num >= sat_bound;
  end

  logic          d_v   [QW+1];
  logic [XW-1:0] d_rem [QW+1];
  logic [QW-1:0] d_q   [QW+1];
  logic [CW-1:0] d_div [QW+1];
  carry_t        d_c   [QW+1];

  always_ff @(posedge clk) begin
    if (rst) d_v[0] <= 1'b0;
    else     d_v[0] <= s3_v;
    d_rem[0] <= sat_num;
    d_q[0]   <= '0;
    d_div[0] <= s3_d;
    d_c[0]   <= ld_c;
  end

  // restoring divider, one quotient bit per stage, MSB first
  for (genvar g = 0; g < QW; g++) begin : g_div
    localparam int K = QW - 1 - g;
    logic [XW-1:0] trial;
    logic          ge;

    assign trial = XW'(d_div[g]) << K;
    assign ge    = d_rem[g] >= trial;

    always_ff @(posedge clk) begin
      if (rst) d_v[g+1] <= 1'b0;
      else     d_v[g+1] <= d_v[g];
      d_rem[g+1] <= ge ? d_rem[g] - trial : d_rem[g];
      d_q[g+1]   <= {d_q[g][QW-2:0], ge};
      d_div[g+1] <= d_div[g];
      d_c[g+1]   <= d_c[g];
    end
  end

  // ------------------------------------------- T stage: clamp and sign
  logic [QW-1:0] q_clamp;
  carry_t        tn_c;

  always_comb begin
    if (!d_c[QW].has)    q_clamp = '0;
    else if (d_c[QW].sat) q_clamp = d_c[QW].neg ? rbi_pkg::SAT_NEG : rbi_pkg::SAT_POS;
    else                  q_clamp = d_q[QW];
    tn_c     = d_c[QW];
    tn_c.sat = d_c[QW].sat && d_c[QW].has;
  end

  logic                 t_v;
  logic signed [QW-1:0] t_val;
  logic [QW-1:0]        t_mag;
  carry_t               t_c;

  always_ff @(posedge clk) begin
    if (rst) t_v <= 1'b0;
    else     t_v <= d_v[QW];
    t_val <= d_c[QW].neg ? -$signed(q_clamp) : $signed(q_clamp);
    t_mag <= q_clamp;
    t_c   <= tn_c;
  end

  // ------------------------------------------- P stage: t * dir products
  logic [CW-1:0] m1, m2;

  assign m1 = t_c.da1[CW-1] ? CW'(-t_c.da1) : CW'(t_c.da1);
  assign m2 = t_c.da2[CW-1] ? CW'(-t_c.da2) : CW'(t_c.da2);

  logic                 p_v;
  logic signed [QW-1:0] p_t;
  logic [MW-1:0]        p_pr1, p_pr2;
  logic                 p_sg1, p_sg2;
  carry_t               p_c;

  always_ff @(posedge clk) begin
    if (rst) p_v <= 1'b0;
    else     p_v <= t_v;
    p_t   <= t_val;
    p_pr1 <= MW'(t_mag) * MW'(m1);
    p_pr2 <= MW'(t_mag) * MW'(m2);
    p_sg1 <= t_val[QW-1] != t_c.da1[CW-1];
    p_sg2 <= t_val[QW-1] != t_c.da2[CW-1];
    p_c   <= t_c;
  end

  // ------------------------------------------- H stage: hit point
  logic [LW-1:0]        sh1, sh2;
  logic signed [HW-1:0] off1, off2;

  assign sh1  = LW'(p_pr1 >> FRAC_BITS);
  assign sh2  = LW'(p_pr2 >> FRAC_BITS);
  assign off1 = $signed({{(HW-50){1'b0}}, sh1[49:0]});
  assign off2 = $signed({{(HW-50){1'b0}}, sh2[49:0]});

  logic                 h_v;
  logic signed [QW-1:0] h_t;
  logic signed [HW-1:0] h_p1, h_p2;
  logic                 h_ov1, h_ov2;
  carry_t               h_c;

  always_ff @(posedge clk) begin
    if (rst) h_v <= 1'b0;
    else     h_v <= p_v;
    h_t   <= p_t;
    h_p1  <= HW'(p_c.sa1) + (p_sg1 ? -off1 : off1);
    h_p2  <= HW'(p_c.sa2) + (p_sg2 ? -off2 : off2);
    h_ov1 <= |sh1[LW-1:50];   // offset too large to lie in any box
    h_ov2 <= |sh2[LW-1:50];
    h_c   <= p_c;
  end

  // ------------------------------------------- C stage: bounds, result
  logic signed [CW-1:0] lo1, hi1, lo2, hi2;
  logic                 w1, w2;

  always_comb begin
    unique case (h_c.a1)
      rbi_pkg::AXIS_X: begin lo1 = box_min_x; hi1 = box_max_x; end
      rbi_pkg::AXIS_Y: begin lo1 = box_min_y; hi1 = box_max_y; end
      default:         begin lo1 = box_min_z; hi1 = box_max_z; end
    endcase
    unique case (h_c.a2)
      rbi_pkg::AXIS_X: begin lo2 = box_min_x; hi2 = box_max_x; end
      rbi_pkg::AXIS_Y: begin lo2 = box_min_y; hi2 = box_max_y; end
      default:         begin lo2 = box_min_z; hi2 = box_max_z; end
    endcase
    w1 = !h_ov1 && (h_p1 >= HW'(lo1)) && (h_p1 <= HW'(hi1));
    w2 = !h_ov2 && (h_p2 >= HW'(lo2)) && (h_p2 <= HW'(hi2));
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else     result_valid <= h_v;
    result.hit             <= h_c.has ? (w1 && w2) : h_c.inside_all;
    result.ray_param       <= h_t;
    result.param_saturated <= h_c.sat;
  end

  // ------------------------------------------- assertions
  `RBI_ASSERT(a_latency, clk, rst, accept |-> ##LAT result_valid, "result word missing")
  `RBI_ASSERT(a_sat_clamp, clk, rst, (result_valid && result.param_saturated) |-> ((result.ray_param == rbi_pkg::SAT_POS) || (result.ray_param == rbi_pkg::SAT_NEG)), "saturated t not at a limit")

endmodule

`default_nettype wire

>>> tb/ray_box_intersection_core_test.sv
// ray_box_intersection_core_test: self-checking bench for the ray/box core.
// Needs rbi_pkg and ray_box_intersection_core; prediction is done in-bench.
`default_nettype none

module ray_box_intersection_core_test;

  localparam int HALF_PERIOD = 5;
  localparam int LATENCY     = 40;   // ray word to result word through the core
  localparam int WATCHDOG    = 5000; // cycles with no handshake of any kind
  localparam int ONE         = 32'h0001_0000;  // 1.0 in Q16.16
  localparam int AXES        = rbi_pkg::AXES;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  rbi_pkg::ray_t    ray = '0;
  logic             result_valid;
  rbi_pkg::result_t result;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [rbi_pkg::CFG_IDX_W-1:0] cfg_index = rbi_pkg::REG_BOX_MIN_X;
  logic [rbi_pkg::FIELD_W-1:0]   cfg_data = '0;

  ray_box_intersection_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .ray          (ray),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Bench copy of the box corners, updated on each accepted cfg word.
  longint box_lo [AXES];
  longint box_hi [AXES];

  rbi_pkg::ray_t    pending_rays [$];   // rays waiting to be driven
  rbi_pkg::result_t expected_hits [$];  // predicted result words, oldest first
  bit      no_idle = 1'b0;     // burst mode: driver never gaps
  bit      failed = 1'b0;
  int      quiet_cycles = 0;
  bit      cfg_seen = 1'b0;

  // Hit point on a side axis: st + trunc(t*dir) must land in [lo, hi].
  function automatic bit on_face(longint t, longint st, longint dr, int k);
    bit [63:0] p;
    longint    off, h;
    p = (64'(t < 0 ? -t : t) * 64'(dr < 0 ? -dr : dr)) >> rbi_pkg::FRAC_BITS_DEF;
    if (p >= (64'd1 << 50))
      return 1'b0;
    off = longint'(p);
    if ((t < 0) != (dr < 0))
      off = -off;
    h = st + off;
    return (h >= box_lo[k]) && (h <= box_hi[k]);
  endfunction

  // Entry parameter and hit flag of one ray against the current box.
  function automatic rbi_pkg::result_t predict_hit(rbi_pkg::ray_t r);
    longint     st [AXES];
    longint     dr [AXES];
    longint     face, f, t;
    bit [63:0]  n, d, q, lim;
    bit [63:0]  best_n, best_d;
    bit [127:0] lhs, rhs;
    bit         neg, sat;
    int         best, in_count;
    rbi_pkg::result_t res;
    st[0] = r.start_x; st[1] = r.start_y; st[2] = r.start_z;
    dr[0] = r.dir_x;   dr[1] = r.dir_y;   dr[2] = r.dir_z;
    best = -1; in_count = 0; t = 0; sat = 1'b0; best_n = 0; best_d = 1;
    for (int i = 0; i < AXES; i++) begin
      // lower bound is tested first, so an inverted slab counts as outside
      if (st[i] < box_lo[i]) begin
        face = box_lo[i];
      end else if (st[i] > box_hi[i]) begin
        face = box_hi[i];
      end else begin
        in_count++;
        continue;
      end
      if (dr[i] == 0)
        continue;
      f = st[i] - face;
      n = 64'(f < 0 ? -f : f);
      d = 64'(dr[i] < 0 ? -dr[i] : dr[i]);
      // exact rational compare n/d > best_n/best_d; earlier axis keeps ties
      lhs = {64'd0, n} * {64'd0, best_d};
      rhs = {64'd0, best_n} * {64'd0, d};
      if (best < 0 || lhs > rhs) begin
        neg = (f < 0) == (dr[i] < 0);
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        q = (n << rbi_pkg::FRAC_BITS_DEF) / d;
        sat = q > lim;
        if (sat)
          q = lim;
        t = neg ? -longint'(q) : longint'(q);
        best_n = n;
        best_d = d;
        best = i;
      end
    end
    if (best < 0) begin
      res.hit = (in_count == AXES);
      res.ray_param = '0;
      res.param_saturated = 1'b0;
    end else begin
      res.hit = on_face(t, st[(best + 1) % AXES], dr[(best + 1) % AXES], (best + 1) % AXES)
             && on_face(t, st[(best + 2) % AXES], dr[(best + 2) % AXES], (best + 2) % AXES);
      res.ray_param = t[31:0];
      res.param_saturated = sat;
    end
    return res;
  endfunction

  // Driver: predicts on acceptance, holds a ray while busy, gaps at random.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        expected_hits.push_back(predict_hit(ray));
      if (start && busy) begin
        start <= 1'b1;  // ray word not taken yet, keep it up
      end else if (pending_rays.size() > 0 && (no_idle || $urandom_range(99) >= 34)) begin
        ray   <= pending_rays.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: each result word is checked against the oldest prediction.
  always @(posedge clk) begin
    rbi_pkg::result_t want;
    if (!rst && result_valid) begin
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected result word hit=%0b t=%h sat=%0b", $time,
                 result.hit, result.ray_param, result.param_saturated);
        failed = 1'b1;
      end else begin
        want = expected_hits.pop_front();
        if (result.hit !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, result.hit);
          failed = 1'b1;
        end
        if (result.ray_param !== want.ray_param) begin
          $display("%0t: ray_param expected %h actual %h", $time,
                   want.ray_param, result.ray_param);
          failed = 1'b1;
        end
        if (result.param_saturated !== want.param_saturated) begin
          $display("%0t: param_saturated expected %0b actual %0b", $time,
                   want.param_saturated, result.param_saturated);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: any handshake counts as progress.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || cfg_seen) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG) begin
      $display("ray_box_intersection_core_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One cfg word; ready is sampled mid-cycle so the edge decides cleanly.
  task automatic write_reg(logic [rbi_pkg::CFG_IDX_W-1:0] idx,
                           logic [rbi_pkg::FIELD_W-1:0] data);
    bit rdy;
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    cfg_valid <= 1'b0;
    cfg_seen = 1'b1;
    if (idx < AXES)
      box_lo[idx] = longint'(signed'(data));
    else
      box_hi[idx - AXES] = longint'(signed'(data));
    @(negedge clk);
    cfg_seen = 1'b0;
  endtask

  // Quiesce: every ray driven and every result back, then pipeline drains.
  task automatic drain();
    while (pending_rays.size() > 0 || start || expected_hits.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic load_box(logic [31:0] x0, logic [31:0] y0, logic [31:0] z0,
                          logic [31:0] x1, logic [31:0] y1, logic [31:0] z1);
    drain();
    write_reg(rbi_pkg::REG_BOX_MIN_X, x0);
    write_reg(rbi_pkg::REG_BOX_MIN_Y, y0);
    write_reg(rbi_pkg::REG_BOX_MIN_Z, z0);
    write_reg(rbi_pkg::REG_BOX_MAX_X, x1);
    write_reg(rbi_pkg::REG_BOX_MAX_Y, y1);
    write_reg(rbi_pkg::REG_BOX_MAX_Z, z1);
  endtask

  function automatic rbi_pkg::ray_t mk_ray(logic [31:0] sx, logic [31:0] sy,
                                           logic [31:0] sz, logic [31:0] dx,
                                           logic [31:0] dy, logic [31:0] dz);
    rbi_pkg::ray_t r;
    r.start_x = sx; r.start_y = sy; r.start_z = sz;
    r.dir_x = dx;   r.dir_y = dy;   r.dir_z = dz;
    return r;
  endfunction

  function automatic longint pick_between(longint lo, longint hi);
    bit [63:0] span;
    if (lo >= hi)
      return lo;
    span = 64'(hi - lo) + 1;
    return lo + longint'({$urandom, $urandom} % span);
  endfunction

  // Mostly rays aimed through a point of the box, some loose, some full noise.
  task automatic queue_random(int count);
    longint p, s, dv, tk;
    logic [31:0] sv [AXES];
    logic [31:0] dvv [AXES];
    int kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(99);
      tk = longint'($urandom_range(1, 6)) * ($urandom_range(1) ? 1 : -1);
      for (int a = 0; a < AXES; a++) begin
        if (kind < 20) begin
          sv[a] = $urandom;
          dvv[a] = $urandom;
        end else begin
          dv = $urandom_range(5) == 0 ? 0
             : longint'($urandom_range(0, 32'h20_0000)) - 64'h10_0000;
          if (box_lo[a] <= box_hi[a])
            p = pick_between(box_lo[a], box_hi[a]);
          else
            p = pick_between(box_hi[a], box_lo[a]);
          if (kind < 40)
            p = p + longint'($urandom_range(0, 32'h8_0000)) - 64'h4_0000;
          s = p - tk * dv;
          if (s > 64'sh7FFF_FFFF || s < -64'sh8000_0000)
            s = p;
          if (s > 64'sh7FFF_FFFF || s < -64'sh8000_0000)
            s = 0;
          sv[a] = s[31:0];
          dvv[a] = dv[31:0];
        end
      end
      pending_rays.push_back(mk_ray(sv[0], sv[1], sv[2], dvv[0], dvv[1], dvv[2]));
    end
  endtask

  function automatic logic [31:0] rnd_lo(output logic [31:0] hi);
    logic [31:0] a, b;
    a = $urandom;
    b = $urandom;
    if ($signed(a) > $signed(b)) begin
      hi = a;
      return b;
    end
    hi = b;
    return a;
  endfunction

  initial begin
    logic [31:0] h0, h1, h2, l0, l1, l2;
    for (int a = 0; a < AXES; a++) begin
      box_lo[a] = 0;
      box_hi[a] = 0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset box is a single point at the origin
    pending_rays.push_back(mk_ray(0, 0, 0, 0, 0, 0));
    pending_rays.push_back(mk_ray(ONE, 0, 0, -ONE, 0, 0));
    queue_random(60);

    // unit box, directed corner cases
    load_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
    pending_rays.push_back(mk_ray(0, 0, 0, 0, 0, 0));                  // inside, no candidate
    pending_rays.push_back(mk_ray(3 * ONE, 0, 0, 0, ONE, 0));          // outside, zero dir
    pending_rays.push_back(mk_ray(3 * ONE, 0, 0, -ONE, 0, 0));         // plain hit
    pending_rays.push_back(mk_ray(3 * ONE, 0, 0, ONE, 0, 0));          // hit behind start
    pending_rays.push_back(mk_ray(2 * ONE, 2 * ONE, 0, -ONE, -ONE, 0)); // tie x/y
    pending_rays.push_back(mk_ray(2 * ONE, 2 * ONE, 2 * ONE, -ONE, -ONE, -ONE));
    pending_rays.push_back(mk_ray(3 * ONE, ONE, 0, -ONE, 0, 0));       // edge, inclusive
    pending_rays.push_back(mk_ray(3 * ONE, ONE + 1, 0, -ONE, 0, 0));   // just off edge
    pending_rays.push_back(mk_ray(32'h7FFF_FFFF, 0, 0, 1, 0, 0));      // negative clamp
    pending_rays.push_back(mk_ray(32'h7FFF_FFFF, 0, 0, -1, 0, 0));     // positive clamp
    pending_rays.push_back(mk_ray(32'h8000_0000, 0, 0, 32'h8000_0000, 0, 0));
    pending_rays.push_back(mk_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                  32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
    pending_rays.push_back(mk_ray(3 * ONE, 3 * ONE, 3 * ONE, 3, 5, 7)); // odd quotients
    pending_rays.push_back(mk_ray('1, '1, '1, '1, '1, '1));
    queue_random(220);

    // widest box, no gaps at all
    load_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    no_idle = 1'b1;
    queue_random(220);
    drain();
    no_idle = 1'b0;

    // inverted box: every axis outside, lower bound as face below it, upper above
    load_box(ONE, 2 * ONE, ONE, -ONE, -ONE, 0);
    queue_random(200);

    // random boxes across the full range
    repeat (4) begin
      l0 = rnd_lo(h0);
      l1 = rnd_lo(h1);
      l2 = rnd_lo(h2);
      load_box(l0, l1, l2, h0, h1, h2);
      queue_random(110);
    end

    // small, offset boxes where aimed rays hit often
    repeat (3) begin
      l0 = $urandom_range(0, 32'h40_0000) - 32'h20_0000;
      l1 = $urandom_range(0, 32'h40_0000) - 32'h20_0000;
      l2 = $urandom_range(0, 32'h40_0000) - 32'h20_0000;
      load_box(l0, l1, l2, l0 + $urandom_range(0, 32'h8_0000),
               l1 + $urandom_range(0, 32'h8_0000), l2 + $urandom_range(0, 32'h8_0000));
      queue_random(80);
    end

    drain();
    if (!failed && expected_hits.size() == 0)
      $display("ray_box_intersection_core_test OK");
    else
      $display("ray_box_intersection_core_test NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
+incdir+hdl
hdl/rbi_pkg.sv
hdl/ray_box_intersection_core.sv
tb/ray_box_intersection_core_test.sv
